// ===== rtl/stsg_pkg.sv =====
package stsg_pkg;

  // field widths of the item and result
  localparam int unsigned N_W    = 32;
  localparam int unsigned F_W    = 17;
  localparam int unsigned A_W    = 15;
  localparam int unsigned S_W    = 16;
  localparam int unsigned RATE_W = 18;

  // defaults of the top level parameters
  localparam int unsigned PHASE_BITS_DEF = 12;
  localparam int unsigned SINE_BITS_DEF  = 16;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 18'd44100;

  // fixed point constants of the table build, q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_Q30    = 64'd1 << 29;
  localparam int unsigned     TAYLOR_TERMS = 7;

  // factorial step (2i)(2i+1) of the taylor series
  function automatic longint unsigned taylor_div(int unsigned i);
    longint unsigned d;
    case (i)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      6:       d = 64'd156;
      default: d = 64'd210;
    endcase
    return d;
  endfunction

  // restoring long division for the taylor steps, run while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // first quadrant sine, argument and result in q2.30
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int unsigned i = 1; i <= TAYLOR_TERMS; i++) begin
      term = (term * x2) >> 30;
      term = div_u64(term, taylor_div(i));
      if ((i & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? (pos - neg) : 64'd0;
  endfunction

  // table magnitude for offset r within the quarter wave
  function automatic longint unsigned sine_mag(int unsigned r, int unsigned qbits,
                                               int unsigned sine_bits);
    longint unsigned peak;
    longint unsigned x;
    longint unsigned s;
    longint unsigned mag;
    peak = (64'd1 << (sine_bits - 1)) - 64'd1;
    x    = (longint'(r) * HALF_PI_Q30) >> qbits;
    s    = sine_q30(x);
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    mag = (s * peak + HALF_Q30) >> 30;
    if (mag > peak) begin
      mag = peak;
    end
    return mag;
  endfunction

endpackage

// ===== rtl/sine_tone_sample_generator.sv =====
// throughput: one item per cycle while the skid entry is empty, set by the bit-per-stage
// remainder and quotient pipelines
// a two-entry output register lets the pipeline run on while one result waits
// reset: sample rate returns to 44100, all pipeline and output valids clear
// the sine table is a constant quarter-wave rom, nothing to fill after reset
module sine_tone_sample_generator
  import stsg_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
  parameter int unsigned SINE_BITS  = SINE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [N_W-1:0]      sample_index_i,
  input  logic [F_W-1:0]      tone_frequency_i,
  input  logic [A_W-1:0]      amplitude_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [S_W-1:0] sample_o
);

  localparam int unsigned QBITS   = PHASE_BITS - 2;
  localparam int unsigned MAG_W   = SINE_BITS - 1;
  localparam int unsigned M_W     = RATE_W + F_W;
  localparam int unsigned PROD_W  = A_W + MAG_W;
  localparam int unsigned ROM_D   = (1 << QBITS) + 1;
  localparam logic [QBITS:0] QUARTER_IDX = (QBITS + 1)'(1) << QBITS;

  typedef logic [MAG_W-1:0] mag_rom_t [ROM_D];

  // quarter-wave magnitude table, offsets 0 to quarter inclusive
  function automatic mag_rom_t build_rom();
    mag_rom_t rom;
    for (int unsigned r = 0; r < ROM_D; r++) begin
      rom[r] = MAG_W'(sine_mag(r, QBITS, SINE_BITS));
    end
    return rom;
  endfunction

  localparam mag_rom_t SINE_ROM = build_rom();

  // configuration register
  logic [RATE_W-1:0] rate_q;
  logic [RATE_W-1:0] fs_q;
  logic              cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == REG_SAMPLE_RATE);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SAMPLE_RATE) ? PDATA_W'(rate_q) : '0;

  // fs_q holds the divisor, a zero rate counts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= SAMPLE_RATE_RST;
      fs_q   <= SAMPLE_RATE_RST;
    end else if (cfg_wr) begin
      rate_q <= pwdata[RATE_W-1:0];
      fs_q   <= (pwdata[RATE_W-1:0] == '0) ? RATE_W'(1) : pwdata[RATE_W-1:0];
    end
  end

  // pipeline advance, held only while the skid entry is occupied
  logic pipe_en;
  logic skid_valid_q;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = !pipe_en;

  // n mod fs, one dividend bit per stage
  logic [N_W-1:0]    v1_q;
  logic [N_W-1:0]    d1_n_q   [N_W];
  logic [RATE_W-1:0] d1_rem_q [N_W];
  logic [F_W-1:0]    d1_f_q   [N_W];
  logic [A_W-1:0]    d1_a_q   [N_W];

  for (genvar s = 0; s < N_W; s++) begin : g_mod1
    logic              pv;
    logic [N_W-1:0]    pn;
    logic [RATE_W-1:0] prem;
    logic [F_W-1:0]    pf;
    logic [A_W-1:0]    pa;
    logic [RATE_W:0]   t;
    logic [RATE_W:0]   diff;
    logic [RATE_W-1:0] rem_d;

    if (s == 0) begin : g_first
      assign pv   = in_valid_i;
      assign pn   = sample_index_i;
      assign prem = '0;
      assign pf   = tone_frequency_i;
      assign pa   = amplitude_i;
    end else begin : g_next
      assign pv   = v1_q[s-1];
      assign pn   = d1_n_q[s-1];
      assign prem = d1_rem_q[s-1];
      assign pf   = d1_f_q[s-1];
      assign pa   = d1_a_q[s-1];
    end

    assign t     = {prem, pn[N_W-1]};
    assign diff  = t - {1'b0, fs_q};
    assign rem_d = (t >= {1'b0, fs_q}) ? diff[RATE_W-1:0] : t[RATE_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[s] <= 1'b0;
      end else if (pipe_en) begin
        v1_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        d1_n_q[s]   <= {pn[N_W-2:0], 1'b0};
        d1_rem_q[s] <= rem_d;
        d1_f_q[s]   <= pf;
        d1_a_q[s]   <= pa;
      end
    end
  end

  // (n mod fs) times f
  logic           vm_q;
  logic [M_W-1:0] m_q;
  logic [A_W-1:0] am_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (pipe_en) begin
      vm_q <= v1_q[N_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_q  <= M_W'(d1_rem_q[N_W-1]) * M_W'(d1_f_q[N_W-1]);
      am_q <= d1_a_q[N_W-1];
    end
  end

  // phase = product mod fs, one bit per stage
  logic [M_W-1:0]    v2_q;
  logic [M_W-1:0]    d2_m_q   [M_W];
  logic [RATE_W-1:0] d2_rem_q [M_W];
  logic [A_W-1:0]    d2_a_q   [M_W];

  for (genvar s = 0; s < M_W; s++) begin : g_mod2
    logic              pv;
    logic [M_W-1:0]    pm;
    logic [RATE_W-1:0] prem;
    logic [A_W-1:0]    pa;
    logic [RATE_W:0]   t;
    logic [RATE_W:0]   diff;
    logic [RATE_W-1:0] rem_d;

    if (s == 0) begin : g_first
      assign pv   = vm_q;
      assign pm   = m_q;
      assign prem = '0;
      assign pa   = am_q;
    end else begin : g_next
      assign pv   = v2_q[s-1];
      assign pm   = d2_m_q[s-1];
      assign prem = d2_rem_q[s-1];
      assign pa   = d2_a_q[s-1];
    end

    assign t     = {prem, pm[M_W-1]};
    assign diff  = t - {1'b0, fs_q};
    assign rem_d = (t >= {1'b0, fs_q}) ? diff[RATE_W-1:0] : t[RATE_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[s] <= 1'b0;
      end else if (pipe_en) begin
        v2_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        d2_m_q[s]   <= {pm[M_W-2:0], 1'b0};
        d2_rem_q[s] <= rem_d;
        d2_a_q[s]   <= pa;
      end
    end
  end

  // table index k = phase * 2^PHASE_BITS / fs, one quotient bit per stage
  logic [PHASE_BITS-1:0] v3_q;
  logic [RATE_W-1:0]     d3_rem_q [PHASE_BITS];
  logic [PHASE_BITS-1:0] d3_k_q   [PHASE_BITS];
  logic [A_W-1:0]        d3_a_q   [PHASE_BITS];

  for (genvar s = 0; s < PHASE_BITS; s++) begin : g_quo
    logic                  pv;
    logic [RATE_W-1:0]     prem;
    logic [PHASE_BITS-1:0] pk;
    logic [A_W-1:0]        pa;
    logic [RATE_W:0]       t;
    logic [RATE_W:0]       diff;
    logic                  qbit;
    logic [RATE_W-1:0]     rem_d;

    if (s == 0) begin : g_first
      assign pv   = v2_q[M_W-1];
      assign prem = d2_rem_q[M_W-1];
      assign pk   = '0;
      assign pa   = d2_a_q[M_W-1];
    end else begin : g_next
      assign pv   = v3_q[s-1];
      assign prem = d3_rem_q[s-1];
      assign pk   = d3_k_q[s-1];
      assign pa   = d3_a_q[s-1];
    end

    assign t     = {prem, 1'b0};
    assign diff  = t - {1'b0, fs_q};
    assign qbit  = (t >= {1'b0, fs_q});
    assign rem_d = qbit ? diff[RATE_W-1:0] : t[RATE_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v3_q[s] <= 1'b0;
      end else if (pipe_en) begin
        v3_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        d3_rem_q[s] <= rem_d;
        d3_k_q[s]   <= {pk[PHASE_BITS-2:0], qbit};
        d3_a_q[s]   <= pa;
      end
    end
  end

  // quadrant fold into a quarter-wave offset
  logic                  vf_q;
  logic [QBITS:0]        idx_q;
  logic                  negf_q;
  logic [A_W-1:0]        af_q;
  logic [PHASE_BITS-1:0] k_last;
  logic [QBITS:0]        off;
  logic [QBITS:0]        idx_d;

  assign k_last = d3_k_q[PHASE_BITS-1];
  assign off    = {1'b0, k_last[QBITS-1:0]};
  assign idx_d  = k_last[QBITS] ? (QUARTER_IDX - off) : off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (pipe_en) begin
      vf_q <= v3_q[PHASE_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      idx_q  <= idx_d;
      negf_q <= k_last[PHASE_BITS-1];
      af_q   <= d3_a_q[PHASE_BITS-1];
    end
  end

  // registered rom read
  logic             vr_q;
  logic [MAG_W-1:0] mag_q;
  logic             negr_q;
  logic [A_W-1:0]   ar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (pipe_en) begin
      vr_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mag_q  <= SINE_ROM[idx_q];
      negr_q <= negf_q;
      ar_q   <= af_q;
    end
  end

  // amplitude times table magnitude
  logic              vp_q;
  logic [PROD_W-1:0] prod_q;
  logic              negp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (pipe_en) begin
      vp_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q <= PROD_W'(ar_q) * PROD_W'(mag_q);
      negp_q <= negr_q;
    end
  end

  // scale down, truncating toward zero, and restore the sign
  logic [A_W-1:0] scaled;
  logic [S_W-1:0] mag_ext;
  logic [S_W-1:0] sample_d;
  logic           push;

  assign scaled   = prod_q[PROD_W-1:MAG_W];
  assign mag_ext  = {1'b0, scaled};
  assign sample_d = negp_q ? (S_W'(0) - mag_ext) : mag_ext;
  assign push     = pipe_en && vp_q;

  // output register and skid entry
  logic           out_valid_q;
  logic [S_W-1:0] out_sample_q;
  logic [S_W-1:0] skid_sample_q;
  logic           out_hold;

  assign out_hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_hold) begin
      if (push) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_hold) begin
      if (push) begin
        skid_sample_q <= sample_d;
      end
    end else if (skid_valid_q) begin
      out_sample_q <= skid_sample_q;
    end else if (push) begin
      out_sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;

endmodule
